FILE: design/rrpc_pkg.sv
package rrpc_pkg;

   localparam int CONTIG_W = 10;
   localparam int POS_W    = 32;
   localparam int MARGIN_W = 20;
   localparam int COUNT_W  = 5;
   localparam int SLOT_W   = 4;
   localparam int CMD_W    = 2;
   localparam int PROX_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;

   // Signed width that holds a position widened by the margin on either side.
   localparam int WIDE_W = POS_W + 2;

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1000);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SINGLE = 2'd1,
      CMD_PAIR   = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEAR_MARGIN  = 1'd0,
      CSR_REGION_COUNT = 1'd1
   } csr_index_type;

   localparam logic [PROX_W-1:0] PROX_FAR    = 2'd0;
   localparam logic [PROX_W-1:0] PROX_NEAR   = 2'd1;
   localparam logic [PROX_W-1:0] PROX_INSIDE = 2'd2;

   // What one lane found for the read and for the mate against its entry.
   typedef struct packed {
      logic read_inside;
      logic read_near;
      logic mate_inside;
      logic mate_near;
   } lane_hit_type;

   typedef struct packed {
      logic contained;
      logic near;
   } match_type;

   // Compare one read against one interval. Positions are widened by two bits
   // so that subtracting or adding the margin never wraps.
   function automatic match_type match_read(
      input logic [CONTIG_W-1:0] entry_contig,
      input logic [POS_W-1:0]    entry_first,
      input logic [POS_W-1:0]    entry_last,
      input logic [MARGIN_W-1:0] margin,
      input logic [CONTIG_W-1:0] read_contig,
      input logic [POS_W-1:0]    read_start,
      input logic [POS_W-1:0]    read_end
   );
      logic signed [WIDE_W-1:0] lo_wide;
      logic signed [WIDE_W-1:0] hi_wide;
      logic signed [WIDE_W-1:0] s_wide;
      logic signed [WIDE_W-1:0] e_wide;
      logic                     same_contig;
      match_type                result;
      same_contig = (entry_contig == read_contig);
      lo_wide = signed'({2'b00, entry_first}) - signed'({(WIDE_W-MARGIN_W)'(0), margin});
      hi_wide = signed'({2'b00, entry_last})  + signed'({(WIDE_W-MARGIN_W)'(0), margin});
      s_wide  = signed'({2'b00, read_start});
      e_wide  = signed'({2'b00, read_end});
      result.contained = same_contig && (entry_first <= read_start) &&
                         (read_end <= entry_last);
      result.near      = same_contig && (lo_wide <= s_wide) && (e_wide <= hi_wide);
      return result;
   endfunction

endpackage

FILE: design/read_region_proximity_classifier_top.sv
// Read region proximity classifier.
//
// Transactions enter on the req_ ports: a transaction is taken at a rising
// clock edge where start is high and busy is low. A load transaction writes
// one interval into the table and produces no response. A classify
// transaction (one read, or a read and its mate) produces exactly one
// response on rsp_proximity, marked by rsp_strobe for one cycle. Unused
// command codes are dropped.
// A classify is registered in stage one, then in the lane result registers
// alongside stage two, then in the merge output register. Throughput is one
// transaction per cycle, since every table entry has its own compare lane
// and the lanes feed a single OR merge stage; busy therefore stays low.
// A load is visible to a classify taken in the very next cycle.
// The receiver cannot stall; responses leave in order, one per classify.
// The csr_ port writes near_margin (index 0) and region_count (index 1).
// Reset returns near_margin to 1000, region_count to 0 and empties the
// pipeline; the table itself is not cleared and an entry must be loaded
// before a region_count that covers it is used.
module read_region_proximity_classifier_top #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rrpc_pkg::CMD_W-1:0]        req_command,
   input  logic [rrpc_pkg::SLOT_W-1:0]       req_region_slot,
   input  logic [rrpc_pkg::CONTIG_W-1:0]     req_region_contig,
   input  logic [rrpc_pkg::POS_W-1:0]        req_region_start,
   input  logic [rrpc_pkg::POS_W-1:0]        req_region_end,
   input  logic [rrpc_pkg::CONTIG_W-1:0]     req_read_contig,
   input  logic [rrpc_pkg::POS_W-1:0]        req_read_start,
   input  logic [rrpc_pkg::POS_W-1:0]        req_read_end,
   input  logic [rrpc_pkg::CONTIG_W-1:0]     req_mate_contig,
   input  logic [rrpc_pkg::POS_W-1:0]        req_mate_start,
   input  logic [rrpc_pkg::POS_W-1:0]        req_mate_end,
   output logic                              rsp_strobe,
   output logic [rrpc_pkg::PROX_W-1:0]       rsp_proximity,
   input  logic                              csr_write_en,
   input  logic [rrpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rrpc_pkg::*;

   logic                accept;
   command_type         cmd;
   logic                load_hit;
   logic                cls_hit;

   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   // Stage one holds the read and mate fields of a classify transaction.
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_pair_ff, s1_pair_in;
   logic [CONTIG_W-1:0] read_contig_ff;
   logic [POS_W-1:0]    read_start_ff;
   logic [POS_W-1:0]    read_end_ff;
   logic [CONTIG_W-1:0] mate_contig_ff;
   logic [POS_W-1:0]    mate_start_ff;
   logic [POS_W-1:0]    mate_end_ff;

   // Stage two travels alongside the registered lane results.
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_pair_ff, s2_pair_in;

   lane_hit_type        hits [TABLE_ENTRIES];

   // Every transaction can be taken in every cycle.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign cmd    = command_type'(req_command);

   assign load_hit = accept && (cmd == CMD_LOAD);
   assign cls_hit  = accept && ((cmd == CMD_SINGLE) || (cmd == CMD_PAIR));

   // Configuration registers. Only the low bits of the write data that fit a
   // register are kept.
   always_comb begin
      margin_in = margin_ff;
      count_in  = count_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_NEAR_MARGIN:  margin_in = csr_wdata[MARGIN_W-1:0];
            CSR_REGION_COUNT: count_in  = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
         count_ff  <= '0;
      end else begin
         margin_ff <= margin_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      s1_valid_in = cls_hit;
      s1_pair_in  = (cmd == CMD_PAIR);
      s2_valid_in = s1_valid_ff;
      s2_pair_in  = s1_pair_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pair_ff     <= s1_pair_in;
      s2_pair_ff     <= s2_pair_in;
      read_contig_ff <= req_read_contig;
      read_start_ff  <= req_read_start;
      read_end_ff    <= req_read_end;
      mate_contig_ff <= req_mate_contig;
      mate_start_ff  <= req_mate_start;
      mate_end_ff    <= req_mate_end;
   end

   // One lane per table entry. A load whose slot lies past the table matches
   // no lane and is dropped.
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_lane
      logic lane_load;
      assign lane_load = load_hit && (int'(req_region_slot) == g);

      rrpc_lane u_lane (
         .clock       (clock),
         .load_en     (lane_load),
         .load_contig (req_region_contig),
         .load_first  (req_region_start),
         .load_last   (req_region_end),
         .margin      (margin_ff),
         .read_contig (read_contig_ff),
         .read_start  (read_start_ff),
         .read_end    (read_end_ff),
         .mate_contig (mate_contig_ff),
         .mate_start  (mate_start_ff),
         .mate_end    (mate_end_ff),
         .hit         (hits[g])
      );
   end

   rrpc_merge #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .cls_valid     (s2_valid_ff),
      .cls_pair      (s2_pair_ff),
      .region_count  (count_ff),
      .hits          (hits),
      .rsp_strobe    (rsp_strobe),
      .rsp_proximity (rsp_proximity)
   );

endmodule

FILE: design/rrpc_lane.sv
module rrpc_lane (
   input  logic                            clock,
   input  logic                            load_en,
   input  logic [rrpc_pkg::CONTIG_W-1:0]   load_contig,
   input  logic [rrpc_pkg::POS_W-1:0]      load_first,
   input  logic [rrpc_pkg::POS_W-1:0]      load_last,
   input  logic [rrpc_pkg::MARGIN_W-1:0]   margin,
   input  logic [rrpc_pkg::CONTIG_W-1:0]   read_contig,
   input  logic [rrpc_pkg::POS_W-1:0]      read_start,
   input  logic [rrpc_pkg::POS_W-1:0]      read_end,
   input  logic [rrpc_pkg::CONTIG_W-1:0]   mate_contig,
   input  logic [rrpc_pkg::POS_W-1:0]      mate_start,
   input  logic [rrpc_pkg::POS_W-1:0]      mate_end,
   output rrpc_pkg::lane_hit_type          hit
);
   import rrpc_pkg::*;

   logic [CONTIG_W-1:0] contig_ff, contig_in;
   logic [POS_W-1:0]    first_ff, first_in;
   logic [POS_W-1:0]    last_ff, last_in;
   lane_hit_type        hit_ff, hit_in;
   match_type           read_match;
   match_type           mate_match;

   // The entry held by this lane; it is only defined once it has been loaded.
   always_comb begin
      contig_in = load_en ? load_contig : contig_ff;
      first_in  = load_en ? load_first  : first_ff;
      last_in   = load_en ? load_last   : last_ff;
   end

   always_comb begin
      read_match = match_read(contig_ff, first_ff, last_ff, margin,
                              read_contig, read_start, read_end);
      mate_match = match_read(contig_ff, first_ff, last_ff, margin,
                              mate_contig, mate_start, mate_end);
      hit_in.read_inside = read_match.contained;
      hit_in.read_near   = read_match.near;
      hit_in.mate_inside = mate_match.contained;
      hit_in.mate_near   = mate_match.near;
   end

   always_ff @(posedge clock) begin
      contig_ff <= contig_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      hit_ff    <= hit_in;
   end

   assign hit = hit_ff;

endmodule

FILE: design/rrpc_merge.sv
module rrpc_merge #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cls_valid,
   input  logic                           cls_pair,
   input  logic [rrpc_pkg::COUNT_W-1:0]   region_count,
   input  rrpc_pkg::lane_hit_type         hits [TABLE_ENTRIES],
   output logic                           rsp_strobe,
   output logic [rrpc_pkg::PROX_W-1:0]    rsp_proximity
);
   import rrpc_pkg::*;

   logic              strobe_ff, strobe_in;
   logic [PROX_W-1:0] prox_ff, prox_in;
   logic              any_read_inside;
   logic              any_read_near;
   logic              any_mate_inside;
   logic              any_mate_near;
   logic [PROX_W-1:0] read_grade;
   logic [PROX_W-1:0] mate_grade;

   // Only the first region_count lanes take part; a count past the table
   // simply enables every lane.
   always_comb begin
      any_read_inside = 1'b0;
      any_read_near   = 1'b0;
      any_mate_inside = 1'b0;
      any_mate_near   = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (int'(region_count) > i) begin
            any_read_inside |= hits[i].read_inside;
            any_read_near   |= hits[i].read_near;
            any_mate_inside |= hits[i].mate_inside;
            any_mate_near   |= hits[i].mate_near;
         end
      end
   end

   always_comb begin
      read_grade = any_read_inside ? PROX_INSIDE : (any_read_near ? PROX_NEAR : PROX_FAR);
      mate_grade = any_mate_inside ? PROX_INSIDE : (any_mate_near ? PROX_NEAR : PROX_FAR);
      prox_in    = (cls_pair && (mate_grade > read_grade)) ? mate_grade : read_grade;
      strobe_in  = cls_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      prox_ff <= prox_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_proximity = prox_ff;

endmodule

FILE: design/rrpc_checker.sv
module rrpc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [rrpc_pkg::CMD_W-1:0]        req_command,
   input logic                              rsp_strobe,
   input logic [rrpc_pkg::PROX_W-1:0]       rsp_proximity
);
   import rrpc_pkg::*;

   logic classify_taken;
   assign classify_taken = start && !busy &&
                           ((req_command == CMD_SINGLE) || (req_command == CMD_PAIR));

   // Every classify transaction is answered by rsp_strobe once it has passed the pipeline.
   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      classify_taken |-> ##3 rsp_strobe)
      else $error("classify transaction was not answered after three cycles");

   // No response appears without a matching earlier classify transaction.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(classify_taken, 3))
      else $error("response without a matching classify transaction");

   // A response carries one of the three defined classes.
   a_class_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_proximity == PROX_FAR) || (rsp_proximity == PROX_NEAR) ||
                      (rsp_proximity == PROX_INSIDE)))
      else $error("response carries an undefined class");

   // Reset empties the pipeline.
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("response right after reset");

endmodule

bind read_region_proximity_classifier_top rrpc_checker u_rrpc_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_command   (req_command),
   .rsp_strobe    (rsp_strobe),
   .rsp_proximity (rsp_proximity)
);
